### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbl failed");

// Next-cycle implication, live during reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

### design/fsalu_pkg.sv
// ----------------------------------------------------------------------------
// fsalu_pkg
// Operator codes, widths and shared types of the four-state ALU.
// ----------------------------------------------------------------------------
package fsalu_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int WW        = 7;

  // operator codes
  localparam logic [4:0] K_AND   = 5'd0;
  localparam logic [4:0] K_OR    = 5'd1;
  localparam logic [4:0] K_XOR   = 5'd2;
  localparam logic [4:0] K_ADDU  = 5'd3;
  localparam logic [4:0] K_ADDS  = 5'd4;
  localparam logic [4:0] K_SUBU  = 5'd5;
  localparam logic [4:0] K_MULU  = 5'd6;
  localparam logic [4:0] K_POWU  = 5'd7;
  localparam logic [4:0] K_DIVU  = 5'd8;
  localparam logic [4:0] K_MODU  = 5'd9;
  localparam logic [4:0] K_SUBS  = 5'd10;
  localparam logic [4:0] K_MULS  = 5'd11;
  localparam logic [4:0] K_POWS  = 5'd12;
  localparam logic [4:0] K_DIVS  = 5'd13;
  localparam logic [4:0] K_REMS  = 5'd14;
  localparam logic [4:0] K_MODS  = 5'd15;
  localparam logic [4:0] K_EQ    = 5'd16;
  localparam logic [4:0] K_CEQ   = 5'd17;
  localparam logic [4:0] K_CZEQ  = 5'd18;
  localparam logic [4:0] K_CXEQ  = 5'd19;
  localparam logic [4:0] K_WEQ   = 5'd20;
  localparam logic [4:0] K_MEQ   = 5'd21;
  localparam logic [4:0] K_NE    = 5'd22;
  localparam logic [4:0] K_LTU   = 5'd23;
  localparam logic [4:0] K_LEU   = 5'd24;
  localparam logic [4:0] K_GTU   = 5'd25;
  localparam logic [4:0] K_GEU   = 5'd26;
  localparam logic [4:0] K_LTS   = 5'd27;
  localparam logic [4:0] K_LES   = 5'd28;
  localparam logic [4:0] K_GTS   = 5'd29;
  localparam logic [4:0] K_GES   = 5'd30;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic div;
  } iter_req_t;

endpackage

### design/fsalu_iter.sv
// ----------------------------------------------------------------------------
// fsalu_iter
// Shared one-bit-per-cycle unit: shift-add multiply or restoring divide
// over the active width. Pulses done for one cycle.
// ----------------------------------------------------------------------------
module fsalu_iter import fsalu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  iter_req_t            req,
  input  logic [MAX_WIDTH-1:0] a,
  input  logic [MAX_WIDTH-1:0] b,
  input  logic [WW-1:0]        w,
  output logic                 done,
  output logic [MAX_WIDTH-1:0] acc_out,
  output logic [MAX_WIDTH-1:0] x_out
);

  logic                 busy;
  logic                 is_div;
  logic [WW-1:0]        cnt;
  logic [MAX_WIDTH-1:0] acc;  // product, or partial remainder
  logic [MAX_WIDTH-1:0] x;    // multiplicand, or dividend/quotient
  logic [MAX_WIDTH-1:0] y;    // multiplier, or divisor
  logic [MAX_WIDTH:0]   r2;
  logic [MAX_WIDTH:0]   diff;
  logic                 ge;
  logic [WW-1:0]        shamt;

  // trial subtract of one divide step
  always_comb begin
    r2    = {acc, x[MAX_WIDTH-1]};
    diff  = r2 - {1'b0, y};
    ge    = (r2 >= {1'b0, y});
    shamt = WW'(MAX_WIDTH) - w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy   <= 1'b1;
        done   <= 1'b0;
        is_div <= req.div;
        cnt    <= w;
        acc    <= '0;
        x      <= req.div ? (a << shamt[5:0]) : a;
        y      <= b;
      end else if (busy) begin
        if (is_div) begin
          acc <= ge ? diff[MAX_WIDTH-1:0] : r2[MAX_WIDTH-1:0];
          x   <= {x[MAX_WIDTH-2:0], ge};
        end else begin
          if (y[0]) begin
            acc <= acc + x;
          end
          x <= x << 1;
          y <= y >> 1;
        end
        cnt  <= cnt - WW'(1);
        done <= (cnt == WW'(1));
        if (cnt == WW'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign acc_out = acc;
  assign x_out   = x;

endmodule

### design/four_state_binary_alu_unit.sv
// ----------------------------------------------------------------------------
// four_state_binary_alu_unit
// Verilog-style binary operator on two four-state operands.
// ----------------------------------------------------------------------------
// One item is in work at a time. Bitwise, add, subtract, compares and all-x
// cases pass through the evaluation and finish states to the result register;
// multiply, divide, remainder and modulo wait between them on the shared
// one-bit-per-cycle multiply/divide unit. Power runs square-and-multiply on that
// unit: up to 2*w multiplies (w = active width), a multiply and a square per set
// exponent bit, a square alone per clear one. A new beat is taken as soon as the
// sequencer is idle, even while the previous result still waits on the output.
module four_state_binary_alu_unit import fsalu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           kind,
  input  logic [WW-1:0]        operand_width,
  input  logic [MAX_WIDTH-1:0] lhs_value,
  input  logic [MAX_WIDTH-1:0] lhs_unknown,
  input  logic [MAX_WIDTH-1:0] rhs_value,
  input  logic [MAX_WIDTH-1:0] rhs_unknown,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAX_WIDTH-1:0] result_value,
  output logic [MAX_WIDTH-1:0] result_unknown,
  output logic [WW-1:0]        result_width
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_UNIT, S_POW, S_PWAIT, S_FIN} state_t;

  state_t               state;
  logic [4:0]           kd;
  logic [WW-1:0]        w;
  logic [MAX_WIDTH-1:0] la, lb, ra, rb;
  logic [MAX_WIDTH-1:0] res_v, res_u;
  logic [MAX_WIDTH-1:0] pw_p, pw_base, pw_e;
  logic                 pw_sq;

  logic [WW-1:0]        w_in;
  logic [MAX_WIDTH-1:0] mask_in, mask, sbit;
  logic [MAX_WIDTH-1:0] known;
  logic                 unk;

  iter_req_t            req;
  logic [MAX_WIDTH-1:0] u_a, u_b;
  logic                 u_done;
  logic [MAX_WIDTH-1:0] u_acc, u_x;

  // evaluation results
  logic [MAX_WIDTH-1:0] ev_v, ev_u;
  logic [1:0]           ev_go;   // 0 finish, 1 unit, 2 power
  logic [MAX_WIDTH-1:0] l1, r1, l0, r0, one, zero, bu;
  logic                 nl, nr;
  logic [MAX_WIDTH-1:0] ml, mr;
  logic [MAX_WIDTH-1:0] lr, rr;
  logic                 t_val, t_x;
  logic [MAX_WIDTH-1:0] wild, cmpm;
  logic                 lt, eq;
  logic [MAX_WIDTH-1:0] sq, sm, fin_v;
  logic [WW-1:0]        fin_w;
  logic                 is_cmp;

  localparam logic [1:0] GO_FIN  = 2'd0;
  localparam logic [1:0] GO_UNIT = 2'd1;
  localparam logic [1:0] GO_POW  = 2'd2;

  // width clamp and masks
  always_comb begin
    if (operand_width == '0) begin
      w_in = WW'(1);
    end else if (operand_width > WW'(MAX_WIDTH)) begin
      w_in = WW'(MAX_WIDTH);
    end else begin
      w_in = operand_width;
    end
    mask_in = (w_in == WW'(MAX_WIDTH)) ? '1 : ((MAX_WIDTH'(1) << w_in[5:0]) - MAX_WIDTH'(1));
    mask    = (w == WW'(MAX_WIDTH)) ? '1 : ((MAX_WIDTH'(1) << w[5:0]) - MAX_WIDTH'(1));
    sbit    = MAX_WIDTH'(1) << 6'(w - WW'(1));
    known   = ~(lb | rb) & mask;
    unk     = |(lb | rb);
    is_cmp  = (kd >= K_EQ) && (kd <= K_GES);
  end

  // per-operator evaluation from the latched operands
  always_comb begin
    ev_v  = '0;
    ev_u  = '0;
    ev_go = GO_FIN;
    req   = '0;
    u_a   = la;
    u_b   = ra;
    l1    = la & ~lb;
    r1    = ra & ~rb;
    l0    = ~la & ~lb & mask;
    r0    = ~ra & ~rb & mask;
    one   = '0;
    zero  = '0;
    bu    = '0;
    nl    = |(la & sbit);
    nr    = |(ra & sbit);
    ml    = nl ? ((MAX_WIDTH'(0) - la) & mask) : la;
    mr    = nr ? ((MAX_WIDTH'(0) - ra) & mask) : ra;
    lr    = (kd >= K_LTS) ? (la ^ sbit) : la;
    rr    = (kd >= K_LTS) ? (ra ^ sbit) : ra;
    lt    = lr < rr;
    eq    = lr == rr;
    wild  = (kd == K_CZEQ) ? ((~la & lb) | (~ra & rb)) : (lb | rb);
    cmpm  = ~rb & mask;
    t_val = 1'b0;
    t_x   = 1'b0;
    if (kd <= K_XOR) begin
      if (kd == K_AND) begin
        one  = l1 & r1;
        zero = l0 | r0;
      end else if (kd == K_OR) begin
        one  = l1 | r1;
        zero = l0 & r0;
      end else begin
        one  = (la ^ ra) & known;
        zero = ~(la ^ ra) & known;
      end
      bu   = ~(one | zero) & mask;
      ev_u = bu;
      ev_v = (one | bu) & mask;
    end else if (kd <= K_MODS) begin
      if (unk || (((kd == K_DIVU) || (kd == K_MODU) || (kd >= K_DIVS)) && (ra == '0))) begin
        ev_v = mask;
        ev_u = mask;
      end else begin
        unique case (kd)
          K_ADDU, K_ADDS: ev_v = (la + ra) & mask;
          K_SUBU, K_SUBS: ev_v = (la - ra) & mask;
          K_MULU, K_MULS: begin
            ev_go     = GO_UNIT;
            req.start = 1'b1;
          end
          K_DIVU, K_MODU: begin
            ev_go     = GO_UNIT;
            req.start = 1'b1;
            req.div   = 1'b1;
          end
          K_DIVS, K_REMS, K_MODS: begin
            ev_go     = GO_UNIT;
            req.start = 1'b1;
            req.div   = 1'b1;
            u_a       = ml;
            u_b       = mr;
          end
          K_POWS: begin
            if (!nr) begin
              ev_go = GO_POW;
            end else if (la == '0) begin
              ev_v = mask;
              ev_u = mask;
            end else if (la == MAX_WIDTH'(1)) begin
              ev_v = MAX_WIDTH'(1);
            end else if (la == mask) begin
              ev_v = ra[0] ? mask : MAX_WIDTH'(1);
            end else begin
              ev_v = '0;
            end
          end
          default: ev_go = GO_POW;  // unsigned power
        endcase
      end
    end else if (is_cmp) begin
      unique case (kd)
        K_EQ, K_NE: begin
          if (|((la ^ ra) & known)) begin
            t_val = 1'b0;
          end else begin
            t_x   = unk;
            t_val = 1'b1;
          end
          if (kd == K_NE && !t_x) begin
            t_val = !t_val;
          end
        end
        K_CEQ:          t_val = (la == ra) && (lb == rb);
        K_CZEQ, K_CXEQ: t_val = ~|(((la ^ ra) | (lb ^ rb)) & ~wild & mask);
        K_WEQ: begin
          if (|((la ^ ra) & cmpm & ~lb)) begin
            t_val = 1'b0;
          end else begin
            t_x   = |(lb & cmpm);
            t_val = 1'b1;
          end
        end
        K_MEQ: t_val = ~|(((la ^ ra) | lb | rb) & mask);
        default: begin
          t_x = unk;
          unique case (kd)
            K_LTU, K_LTS: t_val = lt;
            K_LEU, K_LES: t_val = lt || eq;
            K_GTU, K_GTS: t_val = !(lt || eq);
            default:      t_val = !lt;
          endcase
          t_val = t_val || t_x;
        end
      endcase
      ev_v = {{(MAX_WIDTH-1){1'b0}}, t_val};
      ev_u = {{(MAX_WIDTH-1){1'b0}}, t_x};
    end else begin
      ev_v = mask;
      ev_u = mask;
    end

    // power steps reuse the unit as a multiplier
    if (state == S_POW) begin
      req = '0;
      if (pw_e != '0) begin
        req.start = 1'b1;
        u_a       = pw_e[0] ? pw_p : pw_base;
        u_b       = pw_base;
      end
    end else if (state == S_PWAIT) begin
      req = '0;
      if (u_done && !pw_sq) begin
        req.start = 1'b1;
        u_a       = pw_base;
        u_b       = pw_base;
      end
    end else if (state != S_EVAL) begin
      req = '0;
    end
  end

  // signed divide fix-up of unit results
  always_comb begin
    sq = ((nl != nr) ? (MAX_WIDTH'(0) - u_x) : u_x) & mask;
    sm = (nl ? (MAX_WIDTH'(0) - u_acc) : u_acc) & mask;
    unique case (kd)
      K_DIVU:  fin_v = u_x & mask;
      K_MODU:  fin_v = u_acc & mask;
      K_DIVS:  fin_v = sq;
      K_REMS:  fin_v = sm;
      K_MODS:  fin_v = ((sm != '0) && (nl != nr)) ? ((sm + ra) & mask) : sm;
      default: fin_v = u_acc & mask;
    endcase
    fin_w = is_cmp ? WW'(1) : w;
  end

  fsalu_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .a       (u_a),
    .b       (u_b),
    .w       (w),
    .done    (u_done),
    .acc_out (u_acc),
    .x_out   (u_x)
  );

  assign in_ready = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kd    <= kind;
            w     <= w_in;
            la    <= lhs_value & mask_in;
            lb    <= lhs_unknown & mask_in;
            ra    <= rhs_value & mask_in;
            rb    <= rhs_unknown & mask_in;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_v   <= ev_v;
          res_u   <= ev_u;
          pw_p    <= MAX_WIDTH'(1);
          pw_base <= la;
          pw_e    <= ra;
          unique case (ev_go)
            GO_UNIT: state <= S_UNIT;
            GO_POW:  state <= S_POW;
            default: state <= S_FIN;
          endcase
        end
        S_UNIT: begin
          if (u_done) begin
            res_v <= fin_v;
            res_u <= '0;
            state <= S_FIN;
          end
        end
        S_POW: begin
          if (pw_e == '0) begin
            res_v <= pw_p & mask;
            res_u <= '0;
            state <= S_FIN;
          end else begin
            pw_sq <= !pw_e[0];
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (u_done) begin
            if (!pw_sq) begin
              pw_p  <= u_acc & mask;
              pw_sq <= 1'b1;
            end else begin
              pw_base <= u_acc & mask;
              pw_e    <= pw_e >> 1;
              state   <= S_POW;
            end
          end
        end
        default: begin  // S_FIN
          if (!out_valid || out_ready) begin
            result_value   <= res_v;
            result_unknown <= res_u;
            result_width   <= fin_w;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### design/fsalu_checker.sv
// ----------------------------------------------------------------------------
// fsalu_checker
// Port-level checks on the four-state ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsalu_checker import fsalu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [MAX_WIDTH-1:0] result_value,
  input logic [MAX_WIDTH-1:0] result_unknown,
  input logic [WW-1:0]        result_width
);

  // a stalled result beat stays offered
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // one-bit results carry nothing above bit 0
  `CHK_IMPL(a_cmp_narrow, clk, rst, out_valid && (result_width == WW'(1)), (result_value[MAX_WIDTH-1:1] == '0) && (result_unknown[MAX_WIDTH-1:1] == '0))
  // result width always in range
  `CHK_IMPL(a_width_rng, clk, rst, out_valid, (result_width != '0) && (result_width <= WW'(MAX_WIDTH)))
  // an accepted beat is never echoed in the next cycle
  `CHK_NEXT(a_no_instant, clk, rst, in_valid && in_ready && !out_valid, !out_valid)
  // reset empties the output
  `CHK_NEXT_ALWAYS(a_rst_clear, clk, rst, !out_valid)

endmodule

bind four_state_binary_alu_unit fsalu_checker u_fsalu_checker (.*);
